### src/stateful_packet_filter_unit_macros.svh
// assertion macros shared by the packet filter modules
`ifndef STATEFUL_PACKET_FILTER_UNIT_MACROS_SVH
`define STATEFUL_PACKET_FILTER_UNIT_MACROS_SVH

// same-cycle implication
`define SPFU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("packet filter check failed");

// next-cycle implication
`define SPFU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("packet filter sequencing check failed");

`endif

### src/spfu_pkg.sv
// shared types, constants and match function of the packet filter
package spfu_pkg;

   localparam int RULES_DEF       = 512;
   localparam int BUCKET_BITS_DEF = 10;
   localparam int WAYS_DEF        = 4;

   localparam logic [31:0] HASH_ADDR_MUL = 32'd2654435769;
   localparam logic [7:0]  HASH_PORT_MUL = 8'd158;
   localparam logic [31:0] ANY_ADDR      = 32'hffffffff;
   localparam logic [5:0]  FULL_PREFIX   = 6'd32;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_PACKET = 1'b1;

   typedef enum logic [2:0] {
      RSN_CONN        = 3'd0,
      RSN_RECORDED    = 3'd1,
      RSN_REJECT      = 3'd2,
      RSN_NO_RULE     = 3'd3,
      RSN_NOT_SYN     = 3'd4,
      RSN_BUCKET_FULL = 3'd5,
      RSN_RULE_LOAD   = 3'd6
   } reason_type;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [5:0]  src_len;
      logic [5:0]  dst_len;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic        src_any;
      logic        dst_any;
      logic        permit;
   } rule_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } conn_type;

   typedef struct packed {
      logic       latch;
      logic       rule_write;
      logic       hash_mul;
      logic       hash_add;
      logic       base_calc;
      logic       conn_read;
      logic       conn_check;
      logic       rule_start;
      logic       rule_scan;
      logic       conn_write;
      logic       clear;
      logic       finish;
      logic       res_accept;
      reason_type res_reason;
      logic       res_hit;
      logic       res_use_idx;
   } ctl_type;

   typedef struct packed {
      logic clear_last;
      logic rule_full;
      logic conn_hit;
      logic way_last;
      logic syn;
      logic rule_match;
      logic match_permit;
      logic scan_miss;
      logic free_found;
      logic rsp_free;
   } sts_type;

   function automatic logic prefix_match(input logic [31:0] pkt, input logic [31:0] rule,
                                         input logic [5:0] len);
      logic [5:0]  eff;
      logic [31:0] mask;
      eff  = (len > FULL_PREFIX) ? FULL_PREFIX : len;
      mask = 32'hffffffff << (FULL_PREFIX - eff);
      if (rule == ANY_ADDR || len == 6'd0) begin
         return 1'b1;
      end
      return (pkt & mask) == (rule & mask);
   endfunction

endpackage

### src/spfu_ctrl.sv
// controller: sequences loads, connection lookup, rule scan and insert
`include "stateful_packet_filter_unit_macros.svh"
module spfu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_cmd,
   output logic              req_stall,
   input  spfu_pkg::sts_type sts,
   output spfu_pkg::ctl_type ctl
);
   import spfu_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_HASH_MUL,
      ST_HASH_ADD,
      ST_BASE,
      ST_CONN_RD,
      ST_CONN_CHK,
      ST_RULE_SCAN,
      ST_INSERT,
      ST_FINISH
   } state_type;

   state_type  state_ff;
   logic       res_accept_ff;
   reason_type res_reason_ff;
   logic       res_hit_ff;
   logic       res_use_idx_ff;

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         res_accept_ff  <= 1'b0;
         res_reason_ff  <= RSN_CONN;
         res_hit_ff     <= 1'b0;
         res_use_idx_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (sts.clear_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= (req_cmd == CMD_LOAD) ? ST_LOAD : ST_HASH_MUL;
               end
            end
            ST_LOAD: begin
               res_accept_ff  <= !sts.rule_full;
               res_reason_ff  <= RSN_RULE_LOAD;
               res_hit_ff     <= 1'b0;
               res_use_idx_ff <= !sts.rule_full;
               state_ff       <= ST_FINISH;
            end
            ST_HASH_MUL: state_ff <= ST_HASH_ADD;
            ST_HASH_ADD: state_ff <= ST_BASE;
            ST_BASE:     state_ff <= ST_CONN_RD;
            ST_CONN_RD:  state_ff <= ST_CONN_CHK;
            ST_CONN_CHK: begin
               res_hit_ff     <= 1'b0;
               res_use_idx_ff <= 1'b0;
               if (sts.conn_hit) begin
                  res_accept_ff <= 1'b1;
                  res_reason_ff <= RSN_CONN;
                  state_ff      <= ST_FINISH;
               end else if (!sts.way_last) begin
                  state_ff <= ST_CONN_RD;
               end else if (!sts.syn) begin
                  res_accept_ff <= 1'b0;
                  res_reason_ff <= RSN_NOT_SYN;
                  state_ff      <= ST_FINISH;
               end else begin
                  state_ff <= ST_RULE_SCAN;
               end
            end
            ST_RULE_SCAN: begin
               if (sts.rule_match) begin
                  res_hit_ff     <= 1'b1;
                  res_use_idx_ff <= 1'b1;
                  if (!sts.match_permit) begin
                     res_accept_ff <= 1'b0;
                     res_reason_ff <= RSN_REJECT;
                     state_ff      <= ST_FINISH;
                  end else if (sts.free_found) begin
                     res_accept_ff <= 1'b1;
                     res_reason_ff <= RSN_RECORDED;
                     state_ff      <= ST_INSERT;
                  end else begin
                     res_accept_ff <= 1'b1;
                     res_reason_ff <= RSN_BUCKET_FULL;
                     state_ff      <= ST_FINISH;
                  end
               end else if (sts.scan_miss) begin
                  res_accept_ff <= 1'b0;
                  res_reason_ff <= RSN_NO_RULE;
                  state_ff      <= ST_FINISH;
               end
            end
            ST_INSERT: state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (sts.rsp_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      ctl             = '0;
      ctl.latch       = (state_ff == ST_IDLE) && req_valid;
      ctl.clear       = (state_ff == ST_CLEAR);
      ctl.rule_write  = (state_ff == ST_LOAD) && !sts.rule_full;
      ctl.hash_mul    = (state_ff == ST_HASH_MUL);
      ctl.hash_add    = (state_ff == ST_HASH_ADD);
      ctl.base_calc   = (state_ff == ST_BASE);
      ctl.conn_read   = (state_ff == ST_CONN_RD);
      ctl.conn_check  = (state_ff == ST_CONN_CHK);
      ctl.rule_start  = (state_ff == ST_CONN_CHK) && !sts.conn_hit && sts.way_last && sts.syn;
      ctl.rule_scan   = (state_ff == ST_RULE_SCAN);
      ctl.conn_write  = (state_ff == ST_INSERT);
      ctl.finish      = (state_ff == ST_FINISH) && sts.rsp_free;
      ctl.res_accept  = res_accept_ff;
      ctl.res_reason  = res_reason_ff;
      ctl.res_hit     = res_hit_ff;
      ctl.res_use_idx = res_use_idx_ff;
   end

   `SPFU_ASSERT_IMPLY(a_insert_has_free, clock, reset, state_ff == ST_INSERT, sts.free_found)
   `SPFU_ASSERT_IMPLY(a_scan_only_syn, clock, reset, state_ff == ST_RULE_SCAN, sts.syn)
   `SPFU_ASSERT_NEXT(a_finish_to_idle, clock, reset, ctl.finish, state_ff == ST_IDLE)

endmodule

### src/spfu_dp.sv
// datapath: rule memory, connection memory, hash, compares, result register
`include "stateful_packet_filter_unit_macros.svh"
module spfu_dp #(
   parameter int RULES       = spfu_pkg::RULES_DEF,
   parameter int BUCKET_BITS = spfu_pkg::BUCKET_BITS_DEF,
   parameter int WAYS        = spfu_pkg::WAYS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  spfu_pkg::ctl_type ctl,
   output spfu_pkg::sts_type sts,
   input  logic [31:0]       req_src_addr,
   input  logic [31:0]       req_dst_addr,
   input  logic [5:0]        req_src_prefix_len,
   input  logic [5:0]        req_dst_prefix_len,
   input  logic [15:0]       req_src_port,
   input  logic [15:0]       req_dst_port,
   input  logic              req_src_port_any,
   input  logic              req_dst_port_any,
   input  logic              req_syn_flag,
   input  logic              req_permit,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_accept,
   output logic [2:0]        rsp_reason,
   output logic              rsp_rule_hit,
   output logic [8:0]        rsp_rule_index
);
   import spfu_pkg::*;

   localparam int RAW   = (RULES > 1) ? $clog2(RULES) : 1;
   localparam int RCW   = $clog2(RULES + 1);
   localparam int WIW   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CONNS = (2 ** BUCKET_BITS) * WAYS;
   localparam int CAW   = $clog2(CONNS);
   localparam logic [CAW-1:0] WAYS_C  = CAW'(WAYS);
   localparam logic [CAW-1:0] CLR_END = CAW'(CONNS - 1);
   localparam logic [WIW-1:0] WAY_END = WIW'(WAYS - 1);
   localparam logic [RCW-1:0] RULES_C = RCW'(RULES);

   rule_type rule_mem [RULES];
   conn_type conn_mem [CONNS];

   rule_type        item_ff;
   logic            syn_ff;
   logic [31:0]     sum_a_ff;
   logic [16:0]     sum_p_ff;
   logic [31:0]     prod_a_ff;
   logic [24:0]     prod_p_ff;
   logic [31:0]     hash_ff;
   logic [CAW-1:0]  base_ff;
   logic [WIW-1:0]  way_ff;
   logic [WIW-1:0]  free_way_ff;
   logic            free_found_ff;
   conn_type        conn_rd_ff;
   logic [CAW-1:0]  clr_idx_ff;
   logic [RCW-1:0]  rule_count_ff;
   logic [RCW-1:0]  rd_idx_ff;
   rule_type        rule_rd_ff;
   logic [RAW-1:0]  chk_idx_ff;
   logic            chk_vld_ff;
   logic [RAW-1:0]  hit_idx_ff;
   logic            rsp_valid_ff;
   logic            rsp_accept_ff;
   logic [2:0]      rsp_reason_ff;
   logic            rsp_hit_ff;
   logic [8:0]      rsp_index_ff;

   logic [CAW-1:0]  conn_addr;
   logic            conn_hit;
   logic            rule_match;
   logic [RAW+8:0]  idx_ext;
   conn_type        conn_new;

   assign conn_addr = base_ff + CAW'(ctl.conn_write ? free_way_ff : way_ff);
   assign conn_new  = '{valid: 1'b1, src_addr: item_ff.src_addr, dst_addr: item_ff.dst_addr,
                        src_port: item_ff.src_port, dst_port: item_ff.dst_port};

   assign conn_hit = conn_rd_ff.valid && conn_rd_ff.src_addr == item_ff.src_addr
                     && conn_rd_ff.dst_addr == item_ff.dst_addr
                     && conn_rd_ff.src_port == item_ff.src_port
                     && conn_rd_ff.dst_port == item_ff.dst_port;

   assign rule_match = chk_vld_ff
      && prefix_match(item_ff.src_addr, rule_rd_ff.src_addr, rule_rd_ff.src_len)
      && prefix_match(item_ff.dst_addr, rule_rd_ff.dst_addr, rule_rd_ff.dst_len)
      && (rule_rd_ff.src_any || rule_rd_ff.src_port == item_ff.src_port)
      && (rule_rd_ff.dst_any || rule_rd_ff.dst_port == item_ff.dst_port);

   assign idx_ext = {9'd0, hit_idx_ff};

   always_comb begin
      sts              = '0;
      sts.clear_last   = (clr_idx_ff == CLR_END);
      sts.rule_full    = (rule_count_ff == RULES_C);
      sts.conn_hit     = conn_hit;
      sts.way_last     = (way_ff == WAY_END);
      sts.syn          = syn_ff;
      sts.rule_match   = rule_match;
      sts.match_permit = rule_rd_ff.permit;
      sts.scan_miss    = !rule_match && (rd_idx_ff >= rule_count_ff);
      sts.free_found   = free_found_ff;
      sts.rsp_free     = !rsp_valid_ff || !rsp_stall;
   end

   // beat payload and hash pipeline
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         item_ff  <= '{src_addr: req_src_addr, dst_addr: req_dst_addr,
                       src_len: req_src_prefix_len, dst_len: req_dst_prefix_len,
                       src_port: req_src_port, dst_port: req_dst_port,
                       src_any: req_src_port_any, dst_any: req_dst_port_any,
                       permit: req_permit};
         syn_ff   <= req_syn_flag;
         sum_a_ff <= req_src_addr + req_dst_addr;
         sum_p_ff <= {1'b0, req_src_port} + {1'b0, req_dst_port};
      end
      if (ctl.hash_mul) begin
         prod_a_ff <= sum_a_ff * HASH_ADDR_MUL;
         prod_p_ff <= {8'd0, sum_p_ff} * {17'd0, HASH_PORT_MUL};
      end
      if (ctl.hash_add) hash_ff <= prod_a_ff + {7'd0, prod_p_ff};
      if (ctl.base_calc) base_ff <= CAW'(hash_ff[31 -: BUCKET_BITS]) * WAYS_C;
   end

   // connection table: clearing pass, lookup, insert
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         conn_mem[clr_idx_ff] <= '0;
      end else if (ctl.conn_write) begin
         conn_mem[conn_addr] <= conn_new;
      end
      if (ctl.conn_read) conn_rd_ff <= conn_mem[conn_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff    <= '0;
         way_ff        <= '0;
         free_found_ff <= 1'b0;
         free_way_ff   <= '0;
      end else begin
         if (ctl.clear) clr_idx_ff <= clr_idx_ff + CAW'(1);
         if (ctl.latch) begin
            way_ff        <= '0;
            free_found_ff <= 1'b0;
         end else if (ctl.conn_check) begin
            way_ff <= way_ff + WIW'(1);
            if (!conn_rd_ff.valid && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_way_ff   <= way_ff;
            end
         end
      end
   end

   // rule table: append and in-order scan, one read per cycle
   always_ff @(posedge clock) begin
      if (ctl.rule_write) rule_mem[rule_count_ff[RAW-1:0]] <= item_ff;
      if (ctl.rule_scan && rd_idx_ff < rule_count_ff) begin
         rule_rd_ff <= rule_mem[rd_idx_ff[RAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= '0;
         rd_idx_ff     <= '0;
         chk_vld_ff    <= 1'b0;
      end else begin
         if (ctl.rule_write) rule_count_ff <= rule_count_ff + RCW'(1);
         if (ctl.rule_start) begin
            rd_idx_ff  <= '0;
            chk_vld_ff <= 1'b0;
         end else if (ctl.rule_scan) begin
            if (rd_idx_ff < rule_count_ff) begin
               chk_idx_ff <= rd_idx_ff[RAW-1:0];
               chk_vld_ff <= 1'b1;
               rd_idx_ff  <= rd_idx_ff + RCW'(1);
            end else begin
               chk_vld_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rule_write) begin
         hit_idx_ff <= rule_count_ff[RAW-1:0];
      end else if (ctl.rule_scan && rule_match) begin
         hit_idx_ff <= chk_idx_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctl.finish) begin
         rsp_accept_ff <= ctl.res_accept;
         rsp_reason_ff <= ctl.res_reason;
         rsp_hit_ff    <= ctl.res_hit;
         rsp_index_ff  <= ctl.res_use_idx ? idx_ext[8:0] : 9'd0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accept     = rsp_accept_ff;
   assign rsp_reason     = rsp_reason_ff;
   assign rsp_rule_hit   = rsp_hit_ff;
   assign rsp_rule_index = rsp_index_ff;

   `SPFU_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, rule_count_ff <= RULES_C)
   `SPFU_ASSERT_IMPLY(a_write_not_full, clock, reset, ctl.rule_write, rule_count_ff < RULES_C)
   `SPFU_ASSERT_IMPLY(a_insert_free_way, clock, reset, ctl.conn_write, free_found_ff)

endmodule

### src/stateful_packet_filter_unit.sv
// top level of the stateful packet filter
//
//   channel  handshake               payload
//   req      req_valid / req_stall   cmd, addresses, prefix lengths, ports, flags, permit
//   rsp      rsp_valid / rsp_stall   accept, reason, rule_hit, rule_index
//
// after reset a clearing pass walks the connection table, one entry a cycle
// (2^BUCKET_BITS * WAYS entries, 4096 by default), with req_stall high.
// a rule load appends the rule unless the rule table is full; a packet goes through hash and
// bucket lookup, then a rule scan (one rule read from the rule memory per
// cycle), plus an insert step to record it when the rule permits and a way is free.
// a new beat is taken while the previous result waits in the output register.
module stateful_packet_filter_unit #(
   parameter int RULES       = spfu_pkg::RULES_DEF,
   parameter int BUCKET_BITS = spfu_pkg::BUCKET_BITS_DEF,
   parameter int WAYS        = spfu_pkg::WAYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_dst_addr,
   input  logic [5:0]  req_src_prefix_len,
   input  logic [5:0]  req_dst_prefix_len,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic        req_src_port_any,
   input  logic        req_dst_port_any,
   input  logic        req_syn_flag,
   input  logic        req_permit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accept,
   output logic [2:0]  rsp_reason,
   output logic        rsp_rule_hit,
   output logic [8:0]  rsp_rule_index
);
   import spfu_pkg::*;

   ctl_type ctl;
   sts_type sts;

   spfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   spfu_dp #(
      .RULES       (RULES),
      .BUCKET_BITS (BUCKET_BITS),
      .WAYS        (WAYS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_src_addr       (req_src_addr),
      .req_dst_addr       (req_dst_addr),
      .req_src_prefix_len (req_src_prefix_len),
      .req_dst_prefix_len (req_dst_prefix_len),
      .req_src_port       (req_src_port),
      .req_dst_port       (req_dst_port),
      .req_src_port_any   (req_src_port_any),
      .req_dst_port_any   (req_dst_port_any),
      .req_syn_flag       (req_syn_flag),
      .req_permit         (req_permit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accept         (rsp_accept),
      .rsp_reason         (rsp_reason),
      .rsp_rule_hit       (rsp_rule_hit),
      .rsp_rule_index     (rsp_rule_index)
   );

endmodule
